// ===== hdl/jpvol_pkg.sv =====
package jpvol_pkg;

	localparam int HoldCounterWidth = 16;

	localparam int CfgIndexWidth = 2;
	localparam int CfgDataWidth  = 16;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2
	} cmd_t;

	typedef enum logic [CfgIndexWidth-1:0] {
		REG_VOLUME_MAX  = 2'd0,
		REG_VOLUME_MIN  = 2'd1,
		REG_VOLUME_HOLD = 2'd2
	} reg_index_t;

	// Reset image of the joypad register is 0xcf: upper bits high, both groups
	// selected, no key shown.
	localparam logic [1:0] SelReset    = 2'b00;
	localparam logic [3:0] NibbleReset = 4'hf;
	localparam logic [1:0] UpperBits   = 2'b11;
	localparam logic [3:0] VolumeReset = 4'd10;
	localparam logic [3:0] VolMaxReset = 4'd10;
	localparam logic [3:0] VolMinReset = 4'd0;
	localparam logic [15:0] HoldTicksReset = 16'd1024;

	typedef struct packed {
		logic [1:0]                  sel;     // bit1 button select, bit0 direction select
		logic [3:0]                  nibble;
		logic [HoldCounterWidth-1:0] hold;
		logic [3:0]                  volume;
	} state_t;

	typedef struct packed {
		logic [3:0]  volume_max;
		logic [3:0]  volume_min;
		logic [15:0] hold_ticks;
	} cfg_t;

endpackage

// ===== hdl/jpvol_if.sv =====
interface jpvol_host_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] write_data;
	logic [3:0] direction_keys;
	logic [3:0] button_keys;
	logic       volume_up_key;
	logic       volume_down_key;

	modport source (output valid, output cmd, output write_data, output direction_keys,
		output button_keys, output volume_up_key, output volume_down_key, input ready);
	modport sink (input valid, input cmd, input write_data, input direction_keys,
		input button_keys, input volume_up_key, input volume_down_key, output ready);
endinterface

interface jpvol_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       joypad_irq;
	logic [3:0] volume_level;

	modport source (output valid, output read_data, output joypad_irq, output volume_level,
		input ready);
	modport sink (input valid, input read_data, input joypad_irq, input volume_level,
		output ready);
endinterface

// ===== hdl/joypad_select_register_with_volume_keys.sv =====
// Joypad select register with volume keys.
// A word accepted on host passes the input register, then the result
// register, before it is presented on result.
// Throughput: one word per cycle while the result side keeps taking words; the state update is a single short pass.
// Reset (arst_n low): joypad register reads 0xcf, hold-off counter 0,
// volume 10, volume limits 10/0, hold-off ticks 1024; both channels empty.
module joypad_select_register_with_volume_keys (
	input  logic                                 clk,
	input  logic                                 arst_n,
	jpvol_host_if.sink                           host,
	jpvol_result_if.source                       result,
	input  logic                                 cfg_we,
	input  logic [jpvol_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  logic [jpvol_pkg::CfgDataWidth-1:0]   cfg_data
);

	// Configuration registers, written by the user only while the block is idle; the block does not enforce it.
	jpvol_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.volume_max <= jpvol_pkg::VolMaxReset;
			cfg_q.volume_min <= jpvol_pkg::VolMinReset;
			cfg_q.hold_ticks <= jpvol_pkg::HoldTicksReset;
		end else if (cfg_we) begin
			case (cfg_index)
				jpvol_pkg::REG_VOLUME_MAX:  cfg_q.volume_max <= cfg_data[3:0];
				jpvol_pkg::REG_VOLUME_MIN:  cfg_q.volume_min <= cfg_data[3:0];
				jpvol_pkg::REG_VOLUME_HOLD: cfg_q.hold_ticks <= cfg_data[15:0];
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	// Stage 1: input register holding one host word.
	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic [7:0] write_data_s1;
	logic [3:0] direction_keys_s1;
	logic [3:0] button_keys_s1;
	logic       volume_up_key_s1;
	logic       volume_down_key_s1;

	// Stage 2: result register.
	logic       valid_s2;
	logic [7:0] read_data_s2;
	logic       joypad_irq_s2;
	logic [3:0] volume_level_s2;

	// Advance stage 1 into stage 2 whenever the result slot is free or
	// being taken this cycle; the block state steps at the same edge.
	logic advance;
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign host.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (host.ready) begin
			valid_s1 <= host.valid;
		end
	end

	// Payload holds while stage 1 is stalled.
	always_ff @(posedge clk) begin
		if (host.ready && host.valid) begin
			cmd_s1             <= host.cmd;
			write_data_s1      <= host.write_data;
			direction_keys_s1  <= host.direction_keys;
			button_keys_s1     <= host.button_keys;
			volume_up_key_s1   <= host.volume_up_key;
			volume_down_key_s1 <= host.volume_down_key;
		end
	end

	// Block state: select bits, key nibble, hold-off counter and volume.
	jpvol_pkg::state_t state_q;
	jpvol_pkg::state_t state_next;
	logic              irq_next;

	jpvol_update u_update (
		.cur             (state_q),
		.cfg             (cfg_q),
		.cmd             (cmd_s1),
		.write_data      (write_data_s1),
		.direction_keys  (direction_keys_s1),
		.button_keys     (button_keys_s1),
		.volume_up_key   (volume_up_key_s1),
		.volume_down_key (volume_down_key_s1),
		.nxt             (state_next),
		.irq             (irq_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.sel    <= jpvol_pkg::SelReset;
			state_q.nibble <= jpvol_pkg::NibbleReset;
			state_q.hold   <= '0;
			state_q.volume <= jpvol_pkg::VolumeReset;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result valid: set on advance, clear once taken with nothing behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// The result word reflects the state after this word's update.
	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_s2    <= {jpvol_pkg::UpperBits, state_next.sel, state_next.nibble};
			joypad_irq_s2   <= irq_next;
			volume_level_s2 <= state_next.volume;
		end
	end

	assign result.valid        = valid_s2;
	assign result.read_data    = read_data_s2;
	assign result.joypad_irq   = joypad_irq_s2;
	assign result.volume_level = volume_level_s2;

endmodule

// ===== hdl/jpvol_update.sv =====
module jpvol_update (
	input  jpvol_pkg::state_t cur,
	input  jpvol_pkg::cfg_t   cfg,
	input  logic [1:0]        cmd,
	input  logic [7:0]        write_data,
	input  logic [3:0]        direction_keys,
	input  logic [3:0]        button_keys,
	input  logic              volume_up_key,
	input  logic              volume_down_key,
	output jpvol_pkg::state_t nxt,
	output logic              irq
);

	jpvol_pkg::state_t refreshed;
	logic              hit;
	logic [3:0]        vol_up;
	logic [jpvol_pkg::HoldCounterWidth-1:0] hold_load;

	assign hold_load = jpvol_pkg::HoldCounterWidth'(cfg.hold_ticks);

	// Refresh the nibble and step the volume logic.
	always_comb begin
		refreshed = cur;
		hit       = 1'b0;
		vol_up    = cur.volume;
		// Buttons first, directions override when both are selected.
		if (!cur.sel[1]) begin
			refreshed.nibble = ~button_keys;
			hit              = hit | (|button_keys);
		end
		if (!cur.sel[0]) begin
			refreshed.nibble = ~direction_keys;
			hit              = hit | (|direction_keys);
		end
		if (cur.hold == '0) begin
			if (volume_up_key) begin
				if (cur.volume < cfg.volume_max) begin
					vol_up = cur.volume + 4'd1;
				end
				refreshed.hold = hold_load;
			end
			refreshed.volume = vol_up;
			if (volume_down_key) begin
				if (vol_up > cfg.volume_min) begin
					refreshed.volume = vol_up - 4'd1;
				end
				refreshed.hold = hold_load;
			end
		end else begin
			refreshed.hold = cur.hold - jpvol_pkg::HoldCounterWidth'(1);
		end
	end

	always_comb begin
		nxt = cur;
		irq = 1'b0;
		case (cmd)
			jpvol_pkg::CMD_TICK: begin
				nxt = refreshed;
				irq = hit;
			end
			jpvol_pkg::CMD_READ: begin
				nxt = refreshed;
			end
			jpvol_pkg::CMD_WRITE: begin
				nxt.sel = write_data[5:4];
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	// Codes that the package leaves without a name.
	localparam logic [1:0] CmdUnused = 2'd3;
	localparam logic [jpvol_pkg::CfgIndexWidth-1:0] RegUnused = 2'd3;

	// One result word as the block reports it.
	typedef struct packed {
		logic [7:0] read_data;
		logic       joypad_irq;
		logic [3:0] volume_level;
	} joyp_word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [jpvol_pkg::CfgIndexWidth-1:0] cfg_index;
	logic [jpvol_pkg::CfgDataWidth-1:0]  cfg_data;

	jpvol_host_if   host ();
	jpvol_result_if result ();

	joypad_select_register_with_volume_keys i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.host      (host.sink),
		.result    (result.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the joypad state and its volume settings.
	logic [7:0]  joyp_reg;
	logic [jpvol_pkg::HoldCounterWidth-1:0] hold_left;
	logic [3:0]  vol_now;
	logic [3:0]  vol_max;
	logic [3:0]  vol_min;
	logic [15:0] hold_ticks;

	// Words the block owes us, oldest first.
	joyp_word_t joyp_words_due[$];

	int  mismatches   = 0;
	bit  idle_on      = 1'b0;  // both sides draw random gaps while set
	int  stall_ask    = 0;     // long receiver hold-off, taken once by the checker

	// Clock: 20 ns period.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Safety net: no correct run comes anywhere near this.
	initial begin
		#40_000_000;
		$display("[joypad_select_register_with_volume_keys] ERROR");
		$finish;
	end

	// Advance the shadow state by one accepted word and return what the block
	// must answer. Buttons are copied first and directions after, so directions
	// win when both groups are selected, while the irq still counts a pressed
	// button that got overwritten.
	function automatic joyp_word_t predict_word(input logic [1:0] op, input logic [7:0] wdata,
			input logic [3:0] dirs, input logic [3:0] btns, input logic vup, input logic vdown);
		joyp_word_t w;
		logic hit;
		hit = 1'b0;
		if (op == jpvol_pkg::CMD_TICK || op == jpvol_pkg::CMD_READ) begin
			if (!joyp_reg[5]) begin
				joyp_reg[3:0] = ~btns;
				if (btns != 4'd0)
					hit = 1'b1;
			end
			if (!joyp_reg[4]) begin
				joyp_reg[3:0] = ~dirs;
				if (dirs != 4'd0)
					hit = 1'b1;
			end
			if (hold_left == '0) begin
				if (vup) begin
					if (vol_now < vol_max)
						vol_now = vol_now + 4'd1;
					hold_left = jpvol_pkg::HoldCounterWidth'(hold_ticks);
				end
				if (vdown) begin
					if (vol_now > vol_min)
						vol_now = vol_now - 4'd1;
					hold_left = jpvol_pkg::HoldCounterWidth'(hold_ticks);
				end
			end else begin
				hold_left = hold_left - jpvol_pkg::HoldCounterWidth'(1);
			end
		end else if (op == jpvol_pkg::CMD_WRITE) begin
			joyp_reg[5:4] = wdata[5:4];
		end
		w.read_data    = joyp_reg;
		w.joypad_irq   = (op == jpvol_pkg::CMD_TICK) && hit;
		w.volume_level = vol_now;
		return w;
	endfunction

	// Offer one word after a random gap; predict its answer once it is taken.
	// Valid stays high straight into the next word when no gap is drawn.
	task automatic send_word(input logic [1:0] op, input logic [7:0] wdata,
			input logic [3:0] dirs, input logic [3:0] btns, input logic vup, input logic vdown);
		int gap;
		gap = idle_on ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			host.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		host.valid           <= 1'b1;
		host.cmd             <= op;
		host.write_data      <= wdata;
		host.direction_keys  <= dirs;
		host.button_keys     <= btns;
		host.volume_up_key   <= vup;
		host.volume_down_key <= vdown;
		do @(posedge clk); while (host.ready !== 1'b1);
		joyp_words_due.push_back(predict_word(op, wdata, dirs, btns, vup, vdown));
	endtask

	// Random word: mostly ticks and reads, a fair share of select writes,
	// now and then the unused code. Empty key groups are made common so the
	// irq shows both values. With refresh_only set, only ticks and reads.
	task automatic send_random_word(input bit refresh_only);
		logic [1:0] op;
		int pick;
		pick = refresh_only ? $urandom_range(0, 69) : $urandom_range(0, 99);
		if (pick < 40)
			op = jpvol_pkg::CMD_TICK;
		else if (pick < 70)
			op = jpvol_pkg::CMD_READ;
		else if (pick < 95)
			op = jpvol_pkg::CMD_WRITE;
		else
			op = CmdUnused;
		send_word(op, 8'($urandom_range(0, 255)),
			($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(0, 15)),
			($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(0, 15)),
			($urandom_range(0, 2) == 0), ($urandom_range(0, 2) == 0));
	endtask

	// Drop valid and hold until every owed word is back, then wait on a little.
	task automatic wait_drained();
		host.valid <= 1'b0;
		while (joyp_words_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [jpvol_pkg::CfgIndexWidth-1:0] idx,
			input logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			jpvol_pkg::REG_VOLUME_MAX:  vol_max    = data[3:0];
			jpvol_pkg::REG_VOLUME_MIN:  vol_min    = data[3:0];
			jpvol_pkg::REG_VOLUME_HOLD: hold_ticks = data;
			default: ;
		endcase
	endtask

	// Reprogram all volume settings with the block idle; optionally poke the
	// unused register index, which must change nothing.
	task automatic program_volume(input logic [3:0] vmax, input logic [3:0] vmin,
			input logic [15:0] ticks, input bit stray);
		wait_drained();
		write_reg(jpvol_pkg::REG_VOLUME_MAX, {12'($urandom_range(0, 4095)), vmax});
		write_reg(jpvol_pkg::REG_VOLUME_MIN, {12'($urandom_range(0, 4095)), vmin});
		write_reg(jpvol_pkg::REG_VOLUME_HOLD, ticks);
		if (stray)
			write_reg(RegUnused, 16'($urandom_range(0, 65535)));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Reset image, both groups selected, and the default volume limits.
	task automatic test_reset_state();
		send_word(jpvol_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 1'b0, 1'b0);
		send_word(jpvol_pkg::CMD_TICK, 8'h00, 4'h0, 4'h0, 1'b0, 1'b0);
		send_word(CmdUnused, 8'h00, 4'h0, 4'h0, 1'b0, 1'b0);
		// Up at the default ceiling changes nothing but loads the hold-off.
		send_word(jpvol_pkg::CMD_TICK, 8'h00, 4'h0, 4'h0, 1'b1, 1'b0);
		send_word(jpvol_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 1'b0, 1'b1);
	endtask

	// Run the default hold-off down with random ticks and reads, then step volume.
	task automatic test_reset_hold_off();
		idle_on = 1'b0;
		while (hold_left != '0)
			send_random_word(1'b1);
		send_word(jpvol_pkg::CMD_TICK, 8'h00, 4'h0, 4'h0, 1'b0, 1'b1);
		send_word(jpvol_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 1'b0, 1'b1);
	endtask

	// Group selects: directions override buttons, the overwritten button still
	// raises the irq, no selection freezes the nibble, reads never raise irq.
	task automatic test_group_select();
		idle_on = 1'b1;
		send_word(jpvol_pkg::CMD_WRITE, 8'h00, 4'hf, 4'hf, 1'b0, 1'b0);
		send_word(jpvol_pkg::CMD_TICK, 8'h00, 4'hf, 4'h0, 1'b0, 1'b0);
		send_word(jpvol_pkg::CMD_TICK, 8'h00, 4'h0, 4'hf, 1'b0, 1'b0);
		send_word(jpvol_pkg::CMD_TICK, 8'h00, 4'h5, 4'ha, 1'b0, 1'b0);
		send_word(jpvol_pkg::CMD_READ, 8'h00, 4'hf, 4'hf, 1'b0, 1'b0);
		send_word(jpvol_pkg::CMD_WRITE, 8'h10, 4'h0, 4'h0, 1'b0, 1'b0);
		send_word(jpvol_pkg::CMD_TICK, 8'h00, 4'h6, 4'h9, 1'b0, 1'b0);
		send_word(jpvol_pkg::CMD_WRITE, 8'h20, 4'h0, 4'h0, 1'b0, 1'b0);
		send_word(jpvol_pkg::CMD_TICK, 8'h00, 4'h3, 4'hc, 1'b0, 1'b0);
		send_word(jpvol_pkg::CMD_WRITE, 8'hff, 4'h0, 4'h0, 1'b0, 1'b0);
		send_word(jpvol_pkg::CMD_TICK, 8'h00, 4'hf, 4'hf, 1'b0, 1'b0);
		send_word(CmdUnused, 8'h00, 4'hf, 4'hf, 1'b1, 1'b1);
		send_word(jpvol_pkg::CMD_WRITE, 8'hcf, 4'h0, 4'h0, 1'b0, 1'b0);
		send_word(jpvol_pkg::CMD_READ, 8'hff, 4'h0, 4'h0, 1'b0, 1'b0);
	endtask

	// Volume saturation at both limits, both keys together, limits crossed,
	// and a short hold-off.
	task automatic test_volume_steps();
		program_volume(4'd15, 4'd0, 16'd0, 1'b1);
		repeat (6) send_word(jpvol_pkg::CMD_TICK, 8'h00, 4'h0, 4'h0, 1'b1, 1'b0);
		send_word(jpvol_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 1'b1, 1'b1);
		send_word(jpvol_pkg::CMD_TICK, 8'h00, 4'h0, 4'h0, 1'b0, 1'b1);
		program_volume(4'd0, 4'd15, 16'd0, 1'b0);
		send_word(jpvol_pkg::CMD_TICK, 8'h00, 4'h0, 4'h0, 1'b1, 1'b0);
		send_word(jpvol_pkg::CMD_TICK, 8'h00, 4'h0, 4'h0, 1'b0, 1'b1);
		program_volume(4'd12, 4'd4, 16'd2, 1'b0);
		repeat (4) send_word(jpvol_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 1'b1, 1'b0);
	endtask

	// Random phases, each with its own settings and its own idling mode.
	task automatic test_random_phases(input int phases, input int per_phase);
		logic [3:0] a;
		logic [3:0] b;
		logic [15:0] ticks;
		for (int p = 0; p < phases; p++) begin
			a = 4'($urandom_range(0, 15));
			b = 4'($urandom_range(0, 15));
			if (p % 4 == 0) begin
				a = 4'd15;
				b = 4'd0;
			end
			ticks = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 8));
			// Keep the limits in order most of the time.
			if ($urandom_range(0, 4) != 0 && a < b)
				program_volume(b, a, ticks, $urandom_range(0, 3) == 0);
			else
				program_volume(a, b, ticks, $urandom_range(0, 3) == 0);
			idle_on = ($urandom_range(0, 3) != 0);
			repeat (per_phase) send_random_word(1'b0);
		end
	endtask

	// Hold the result side for a long stretch while words keep coming, so the
	// block fills and pushes back; then pause the sender until all is back.
	task automatic test_backpressure();
		idle_on   = 1'b0;
		stall_ask = 150;
		repeat (20) send_random_word(1'b0);
		wait_drained();
		repeat (20) send_random_word(1'b0);
	endtask

	// Largest hold-off: one press locks the volume keys for the rest of the run.
	task automatic test_max_hold();
		program_volume(4'd15, 4'd0, 16'hffff, 1'b0);
		while (hold_left != '0)
			send_word(jpvol_pkg::CMD_TICK, 8'h00, 4'h0, 4'h0, 1'b0, 1'b0);
		send_word(jpvol_pkg::CMD_TICK, 8'h00, 4'h0, 4'h0, 1'b1, 1'b0);
		repeat (5) send_word(jpvol_pkg::CMD_READ, 8'h00, 4'h0, 4'h0, 1'b1, 1'b1);
	endtask

	// Result checker: draw a stall per word, take the word, compare field by field.
	initial begin : result_checker
		int stall;
		joyp_word_t want;
		result.ready = 1'b0;
		forever begin
			if (stall_ask > 0) begin
				stall     = stall_ask;
				stall_ask = 0;
			end else begin
				stall = idle_on ? $urandom_range(0, 13) : 0;
			end
			if (stall > 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (result.valid !== 1'b1);
			if (joyp_words_due.size() == 0) begin
				$display("%0t: word with none owed: read_data %h irq %b volume %0d", $time,
					result.read_data, result.joypad_irq, result.volume_level);
				mismatches++;
			end else begin
				want = joyp_words_due.pop_front();
				if (result.read_data !== want.read_data) begin
					$display("%0t: read_data expected %h actual %h", $time,
						want.read_data, result.read_data);
					mismatches++;
				end
				if (result.joypad_irq !== want.joypad_irq) begin
					$display("%0t: joypad_irq expected %b actual %b", $time,
						want.joypad_irq, result.joypad_irq);
					mismatches++;
				end
				if (result.volume_level !== want.volume_level) begin
					$display("%0t: volume_level expected %0d actual %0d", $time,
						want.volume_level, result.volume_level);
					mismatches++;
				end
			end
		end
	end

	// Main sequence: reset once, then each test in turn.
	initial begin
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = jpvol_pkg::REG_VOLUME_MAX;
		cfg_data              = '0;
		host.valid            = 1'b0;
		host.cmd              = jpvol_pkg::CMD_TICK;
		host.write_data       = '0;
		host.direction_keys   = '0;
		host.button_keys      = '0;
		host.volume_up_key    = 1'b0;
		host.volume_down_key  = 1'b0;
		// Shadow state starts at the reset image.
		joyp_reg   = {jpvol_pkg::UpperBits, jpvol_pkg::SelReset, jpvol_pkg::NibbleReset};
		hold_left  = '0;
		vol_now    = jpvol_pkg::VolumeReset;
		vol_max    = jpvol_pkg::VolMaxReset;
		vol_min    = jpvol_pkg::VolMinReset;
		hold_ticks = jpvol_pkg::HoldTicksReset;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_reset_hold_off();
		test_group_select();
		test_volume_steps();
		test_random_phases(2, 20);
		test_backpressure();
		test_random_phases(2, 20);
		test_max_hold();

		// Let every owed word come home, then watch for strays before the verdict.
		wait_drained();
		repeat (5) @(posedge clk);
		if (mismatches == 0 && joyp_words_due.size() == 0)
			$display("[joypad_select_register_with_volume_keys] OK");
		else
			$display("[joypad_select_register_with_volume_keys] ERROR");
		$finish;
	end

endmodule
